// ===== design/tcf_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Tilt complementary filter package
// Shared types, constants, the micro-op program and the CORDIC angle table.
// ---------------------------------------------------------------------------
package tcf_pkg;

   // CORDIC configuration.
   localparam int CordicIterations = 16;
   localparam int IterWidth        = 5;

   // Program counter and register reset values.
   localparam int PcWidth = 6;
   localparam logic [19:0] SamplePeriodReset = 20'd1049;
   localparam logic [15:0] BlendWeightReset  = 16'd64225;

   // Fixed-point constants in Q0.16.
   localparam logic signed [18:0] InvSqrt2      = 19'sd46341;
   localparam logic signed [18:0] CordicInvGain = 19'sd39797;

   // Configuration register indexes.
   localparam logic [7:0] CsrSamplePeriod = 8'd0;
   localparam logic [7:0] CsrBlendWeight  = 8'd1;

   typedef enum logic [2:0] {
      ST_IDLE, ST_ISSUE, ST_ACC, ST_CORDIC, ST_DONE
   } state_type;

   typedef enum logic [1:0] {OK_MAC, OK_STORE, OK_CORDIC, OK_END} op_kind_type;

   typedef enum logic [3:0] {
      A_SUM_G, A_DIF_G, A_SUM_A, A_DIF_A, A_CX_HI, A_CX_LO, A_DT,
      A_Q0, A_Q1, A_S_HI, A_S_LO, A_QA0, A_QA1
   } asel_type;

   typedef enum logic [2:0] {
      B_ISQ2, B_GAIN, B_RATE0, B_RATE1, B_EIGHT, B_MU, B_WQ
   } bsel_type;

   typedef enum logic [1:0] {SH_0, SH_8, SH_16} shift_type;

   typedef enum logic [3:0] {
      D_NONE, D_RATE0, D_RATE1, D_XR, D_YR, D_CINIT_A, D_CINIT_B, D_CINIT_C,
      D_CINIT_D, D_H, D_QA0, D_QA1, D_S, D_TILT0, D_TILT1
   } dest_type;

   typedef struct packed {
      op_kind_type kind;
      asel_type    asel;
      bsel_type    bsel;
      shift_type   shift;
      logic        clear;
      dest_type    dest;
   } micro_op_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                 load;
      logic                 mul_en;
      logic                 acc_en;
      logic                 store_en;
      logic                 cordic_en;
      micro_op_type         op;
      logic [IterWidth-1:0] iter;
   } cmd_type;

   function automatic micro_op_type mac(input asel_type a, input bsel_type b,
                                        input shift_type sh, input logic clr);
      micro_op_type m;
      m.kind  = OK_MAC;
      m.asel  = a;
      m.bsel  = b;
      m.shift = sh;
      m.clear = clr;
      m.dest  = D_NONE;
      return m;
   endfunction

   function automatic micro_op_type store(input dest_type d);
      micro_op_type m;
      m       = mac(A_SUM_G, B_ISQ2, SH_0, 1'b0);
      m.kind  = OK_STORE;
      m.dest  = d;
      return m;
   endfunction

   function automatic micro_op_type special(input op_kind_type k);
      micro_op_type m;
      m      = mac(A_SUM_G, B_ISQ2, SH_0, 1'b0);
      m.kind = k;
      return m;
   endfunction

   // Micro-op program for one sample.
   function automatic micro_op_type program_entry(input logic [PcWidth-1:0] pc);
      micro_op_type m;
      case (pc)
         6'd0:  m = mac(A_SUM_G, B_ISQ2, SH_0, 1'b1);
         6'd1:  m = store(D_RATE0);
         6'd2:  m = mac(A_DIF_G, B_ISQ2, SH_0, 1'b1);
         6'd3:  m = store(D_RATE1);
         6'd4:  m = mac(A_SUM_A, B_ISQ2, SH_0, 1'b1);
         6'd5:  m = store(D_XR);
         6'd6:  m = mac(A_DIF_A, B_ISQ2, SH_0, 1'b1);
         6'd7:  m = store(D_YR);
         6'd8:  m = store(D_CINIT_A);
         6'd9:  m = special(OK_CORDIC);
         6'd10: m = mac(A_CX_HI, B_GAIN, SH_16, 1'b1);
         6'd11: m = mac(A_CX_LO, B_GAIN, SH_0, 1'b0);
         6'd12: m = store(D_H);
         6'd13: m = store(D_CINIT_B);
         6'd14: m = special(OK_CORDIC);
         6'd15: m = store(D_QA0);
         6'd16: m = store(D_CINIT_C);
         6'd17: m = special(OK_CORDIC);
         6'd18: m = mac(A_CX_HI, B_GAIN, SH_16, 1'b1);
         6'd19: m = mac(A_CX_LO, B_GAIN, SH_0, 1'b0);
         6'd20: m = store(D_H);
         6'd21: m = store(D_CINIT_D);
         6'd22: m = special(OK_CORDIC);
         6'd23: m = store(D_QA1);
         6'd24: m = mac(A_DT, B_RATE0, SH_0, 1'b1);
         6'd25: m = mac(A_Q0, B_EIGHT, SH_16, 1'b0);
         6'd26: m = store(D_S);
         6'd27: m = mac(A_S_HI, B_MU, SH_16, 1'b1);
         6'd28: m = mac(A_S_LO, B_MU, SH_0, 1'b0);
         6'd29: m = mac(A_QA0, B_WQ, SH_8, 1'b0);
         6'd30: m = store(D_TILT0);
         6'd31: m = mac(A_DT, B_RATE1, SH_0, 1'b1);
         6'd32: m = mac(A_Q1, B_EIGHT, SH_16, 1'b0);
         6'd33: m = store(D_S);
         6'd34: m = mac(A_S_HI, B_MU, SH_16, 1'b1);
         6'd35: m = mac(A_S_LO, B_MU, SH_0, 1'b0);
         6'd36: m = mac(A_QA1, B_WQ, SH_8, 1'b0);
         6'd37: m = store(D_TILT1);
         default: m = special(OK_END);
      endcase
      return m;
   endfunction

   // atan(2^-i) in units of 2^-24 rad.
   function automatic logic signed [25:0] atan_entry(input logic [IterWidth-1:0] i);
      logic [25:0] one;
      logic signed [25:0] r;
      one = 26'd1;
      case (i)
         5'd0:    r = 26'sd13176795;
         5'd1:    r = 26'sd7778716;
         5'd2:    r = 26'sd4110060;
         5'd3:    r = 26'sd2086331;
         5'd4:    r = 26'sd1047214;
         5'd5:    r = 26'sd524117;
         5'd6:    r = 26'sd262123;
         5'd7:    r = 26'sd131069;
         default: r = signed'(one << (5'd24 - i));
      endcase
      return r;
   endfunction

endpackage

// ===== design/tilt_complementary_filter.sv =====
`timescale 1ns / 1ps
// A response follows an accepted req beat after four CORDIC passes and 18
// multiply-accumulate steps, each an issue and an accumulate state, on one multiplier.
// One sample at a time: a new req beat is taken the cycle after the rsp beat is taken.
// Reset: synchronous; clears both tilt angles and reloads the configuration defaults.
// ---------------------------------------------------------------------------
// Tilt complementary filter
// Accelerometer tilt by CORDIC blended with integrated gyro rates.
// ---------------------------------------------------------------------------
module tilt_complementary_filter (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_accel_x,
   input  logic signed [15:0] req_accel_y,
   input  logic signed [15:0] req_accel_z,
   input  logic signed [15:0] req_gyro_x,
   input  logic signed [15:0] req_gyro_y,
   input  logic signed [15:0] req_gyro_z,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_tilt_first,
   output logic signed [15:0] rsp_tilt_second,
   output logic signed [15:0] rsp_rate_first,
   output logic signed [15:0] rsp_rate_second,
   output logic signed [15:0] rsp_rate_yaw,
   output logic               rsp_accel_invalid,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [7:0]         csr_index,
   input  logic [19:0]        csr_wdata
);

   tcf_pkg::cmd_type cmd;

   // Configuration writes are always taken.
   assign csr_ready = 1'b1;

   tcf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   tcf_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .csr_valid         (csr_valid),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_accel_x       (req_accel_x),
      .req_accel_y       (req_accel_y),
      .req_accel_z       (req_accel_z),
      .req_gyro_x        (req_gyro_x),
      .req_gyro_y        (req_gyro_y),
      .req_gyro_z        (req_gyro_z),
      .rsp_tilt_first    (rsp_tilt_first),
      .rsp_tilt_second   (rsp_tilt_second),
      .rsp_rate_first    (rsp_rate_first),
      .rsp_rate_second   (rsp_rate_second),
      .rsp_rate_yaw      (rsp_rate_yaw),
      .rsp_accel_invalid (rsp_accel_invalid)
   );

endmodule

// ===== design/tcf_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Tilt filter controller
// Steps through the micro-op program and drives the datapath commands.
// ---------------------------------------------------------------------------
module tcf_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tcf_pkg::cmd_type cmd
);

   tcf_pkg::state_type                   state_ff, state_in;
   logic [tcf_pkg::PcWidth-1:0]          pc_ff, pc_in;
   logic [tcf_pkg::IterWidth-1:0]        iter_ff, iter_in;
   tcf_pkg::micro_op_type                op;
   logic                                 last_iter;

   assign op        = tcf_pkg::program_entry(pc_ff);
   assign last_iter = (iter_ff == tcf_pkg::IterWidth'(tcf_pkg::CordicIterations - 1));

   // Next state, program counter and iteration counter.
   always_comb begin
      state_in = state_ff;
      pc_in    = pc_ff;
      iter_in  = iter_ff;
      case (state_ff)
         tcf_pkg::ST_IDLE: begin
            pc_in = '0;
            if (req_valid) begin
               state_in = tcf_pkg::ST_ISSUE;
            end
         end
         tcf_pkg::ST_ISSUE: begin
            iter_in = '0;
            case (op.kind)
               tcf_pkg::OK_MAC:    state_in = tcf_pkg::ST_ACC;
               tcf_pkg::OK_STORE:  pc_in = pc_ff + 1'b1;
               tcf_pkg::OK_CORDIC: state_in = tcf_pkg::ST_CORDIC;
               default:            state_in = tcf_pkg::ST_DONE;
            endcase
         end
         tcf_pkg::ST_ACC: begin
            pc_in    = pc_ff + 1'b1;
            state_in = tcf_pkg::ST_ISSUE;
         end
         tcf_pkg::ST_CORDIC: begin
            iter_in = iter_ff + 1'b1;
            if (last_iter) begin
               pc_in    = pc_ff + 1'b1;
               state_in = tcf_pkg::ST_ISSUE;
            end
         end
         tcf_pkg::ST_DONE: begin
            if (rsp_ready) begin
               state_in = tcf_pkg::ST_IDLE;
            end
         end
         default: state_in = tcf_pkg::ST_IDLE;
      endcase
   end

   // Commands and handshake outputs.
   always_comb begin
      req_ready     = (state_ff == tcf_pkg::ST_IDLE);
      rsp_valid     = (state_ff == tcf_pkg::ST_DONE);
      cmd.load      = (state_ff == tcf_pkg::ST_IDLE) && req_valid;
      cmd.mul_en    = (state_ff == tcf_pkg::ST_ISSUE) && (op.kind == tcf_pkg::OK_MAC);
      cmd.store_en  = (state_ff == tcf_pkg::ST_ISSUE) && (op.kind == tcf_pkg::OK_STORE);
      cmd.acc_en    = (state_ff == tcf_pkg::ST_ACC);
      cmd.cordic_en = (state_ff == tcf_pkg::ST_CORDIC);
      cmd.op        = op;
      cmd.iter      = iter_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tcf_pkg::ST_IDLE;
         pc_ff    <= '0;
         iter_ff  <= '0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
         iter_ff  <= iter_in;
      end
   end

endmodule

// ===== design/tcf_datapath.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Tilt filter datapath
// Shared multiply-accumulate unit, CORDIC vectoring unit, and result registers.
// ---------------------------------------------------------------------------
module tcf_datapath (
   input  logic               clock,
   input  logic               reset,
   input  tcf_pkg::cmd_type   cmd,
   input  logic               csr_valid,
   input  logic [7:0]         csr_index,
   input  logic [19:0]        csr_wdata,
   input  logic signed [15:0] req_accel_x,
   input  logic signed [15:0] req_accel_y,
   input  logic signed [15:0] req_accel_z,
   input  logic signed [15:0] req_gyro_x,
   input  logic signed [15:0] req_gyro_y,
   input  logic signed [15:0] req_gyro_z,
   output logic signed [15:0] rsp_tilt_first,
   output logic signed [15:0] rsp_tilt_second,
   output logic signed [15:0] rsp_rate_first,
   output logic signed [15:0] rsp_rate_second,
   output logic signed [15:0] rsp_rate_yaw,
   output logic               rsp_accel_invalid
);

   function automatic logic signed [15:0] sat16(input logic signed [59:0] v);
      logic signed [15:0] r;
      if (v > 60'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -60'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   // Configuration registers.
   logic [19:0] dt_ff;
   logic [15:0] mu_ff;

   // Sample beat registers.
   logic signed [15:0] ax_ff, ay_ff, gx_ff, gy_ff, gz_ff;
   logic [32:0]        za_ff;
   logic               invalid_ff;

   // Intermediate results.
   logic signed [16:0] rate0_ff, rate1_ff;
   logic signed [33:0] xr_ff, yr_ff, h_ff;
   logic signed [26:0] qa0_ff, qa1_ff;
   logic signed [37:0] s_ff;
   logic signed [15:0] q0_ff, q1_ff;

   // Multiply-accumulate unit.
   logic signed [26:0] a_mux;
   logic signed [18:0] b_mux;
   logic signed [45:0] prod_ff, prod_in;
   logic signed [59:0] acc_ff, acc_in, acc_base, prod_shift;
   logic signed [59:0] rnd16, rnd35;

   // CORDIC registers.
   logic signed [39:0] cx_ff, cy_ff, dx, dy;
   logic signed [26:0] cz_ff, atan_val;

   logic [16:0] az_abs;

   assign az_abs = req_accel_z[15] ? 17'(-{1'b1, req_accel_z}) : {1'b0, req_accel_z};

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         dt_ff <= tcf_pkg::SamplePeriodReset;
         mu_ff <= tcf_pkg::BlendWeightReset;
      end else if (csr_valid) begin
         case (csr_index)
            tcf_pkg::CsrSamplePeriod: dt_ff <= csr_wdata;
            tcf_pkg::CsrBlendWeight:  mu_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // Capture the input beat.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ax_ff      <= req_accel_x;
         ay_ff      <= req_accel_y;
         gx_ff      <= req_gyro_x;
         gy_ff      <= req_gyro_y;
         gz_ff      <= req_gyro_z;
         za_ff      <= {az_abs, 16'b0};
         invalid_ff <= (req_accel_x == 16'sd0) && (req_accel_y == 16'sd0) &&
                       (req_accel_z == 16'sd0);
      end
   end

   // Operand selection.
   always_comb begin
      case (cmd.op.asel)
         tcf_pkg::A_SUM_G: a_mux = 27'(gx_ff) + 27'(gy_ff);
         tcf_pkg::A_DIF_G: a_mux = 27'(gy_ff) - 27'(gx_ff);
         tcf_pkg::A_SUM_A: a_mux = 27'(ax_ff) + 27'(ay_ff);
         tcf_pkg::A_DIF_A: a_mux = 27'(ay_ff) - 27'(ax_ff);
         tcf_pkg::A_CX_HI: a_mux = 27'(cx_ff >>> 16);
         tcf_pkg::A_CX_LO: a_mux = signed'({11'b0, cx_ff[15:0]});
         tcf_pkg::A_DT:    a_mux = signed'({7'b0, dt_ff});
         tcf_pkg::A_Q0:    a_mux = 27'(q0_ff);
         tcf_pkg::A_Q1:    a_mux = 27'(q1_ff);
         tcf_pkg::A_S_HI:  a_mux = 27'(s_ff >>> 16);
         tcf_pkg::A_S_LO:  a_mux = signed'({11'b0, s_ff[15:0]});
         tcf_pkg::A_QA0:   a_mux = qa0_ff;
         tcf_pkg::A_QA1:   a_mux = qa1_ff;
         default:          a_mux = '0;
      endcase
   end

   // With no usable accelerometer the blend keeps the gyro update alone.
   always_comb begin
      case (cmd.op.bsel)
         tcf_pkg::B_ISQ2:  b_mux = tcf_pkg::InvSqrt2;
         tcf_pkg::B_GAIN:  b_mux = tcf_pkg::CordicInvGain;
         tcf_pkg::B_RATE0: b_mux = 19'(rate0_ff);
         tcf_pkg::B_RATE1: b_mux = 19'(rate1_ff);
         tcf_pkg::B_EIGHT: b_mux = 19'sd8;
         tcf_pkg::B_MU:    b_mux = invalid_ff ? 19'sd65536 : signed'({3'b0, mu_ff});
         tcf_pkg::B_WQ:    b_mux = invalid_ff ? 19'sd0 :
                                   19'sd65536 - signed'({3'b0, mu_ff});
         default:          b_mux = '0;
      endcase
   end

   assign prod_in  = 46'(a_mux) * 46'(b_mux);
   assign acc_base = cmd.op.clear ? 60'sd0 : acc_ff;

   always_comb begin
      case (cmd.op.shift)
         tcf_pkg::SH_8:  prod_shift = 60'(prod_ff) <<< 8;
         tcf_pkg::SH_16: prod_shift = 60'(prod_ff) <<< 16;
         default:        prod_shift = 60'(prod_ff);
      endcase
   end

   assign acc_in = acc_base + prod_shift;
   assign rnd16  = (acc_ff + 60'sd32768) >>> 16;
   assign rnd35  = (acc_ff + (60'sd1 <<< 34)) >>> 35;

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
      if (cmd.acc_en) begin
         acc_ff <= acc_in;
      end
   end

   // Result stores from the accumulator.
   always_ff @(posedge clock) begin
      if (reset) begin
         q0_ff <= '0;
         q1_ff <= '0;
      end else if (cmd.store_en) begin
         case (cmd.op.dest)
            tcf_pkg::D_TILT0: q0_ff <= sat16(rnd35);
            tcf_pkg::D_TILT1: q1_ff <= sat16(rnd35);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.store_en) begin
         case (cmd.op.dest)
            tcf_pkg::D_RATE0: rate0_ff <= rnd16[16:0];
            tcf_pkg::D_RATE1: rate1_ff <= rnd16[16:0];
            tcf_pkg::D_XR:    xr_ff    <= acc_ff[33:0];
            tcf_pkg::D_YR:    yr_ff    <= acc_ff[33:0];
            tcf_pkg::D_H:     h_ff     <= rnd16[33:0];
            tcf_pkg::D_QA0:   qa0_ff   <= cz_ff;
            tcf_pkg::D_QA1:   qa1_ff   <= -cz_ff;
            tcf_pkg::D_S:     s_ff     <= acc_ff[37:0];
            default: ;
         endcase
      end
   end

   // CORDIC vectoring step: rotate toward the positive x axis.
   assign dx       = cy_ff >>> cmd.iter;
   assign dy       = cx_ff >>> cmd.iter;
   assign atan_val = 27'(tcf_pkg::atan_entry(cmd.iter));

   always_ff @(posedge clock) begin
      if (cmd.store_en) begin
         case (cmd.op.dest)
            tcf_pkg::D_CINIT_A: begin
               cx_ff <= signed'({7'b0, za_ff});
               cy_ff <= 40'(xr_ff);
               cz_ff <= '0;
            end
            tcf_pkg::D_CINIT_B: begin
               cx_ff <= 40'(h_ff);
               cy_ff <= 40'(yr_ff);
               cz_ff <= '0;
            end
            tcf_pkg::D_CINIT_C: begin
               cx_ff <= signed'({7'b0, za_ff});
               cy_ff <= 40'(yr_ff);
               cz_ff <= '0;
            end
            tcf_pkg::D_CINIT_D: begin
               cx_ff <= 40'(h_ff);
               cy_ff <= 40'(xr_ff);
               cz_ff <= '0;
            end
            default: ;
         endcase
      end else if (cmd.cordic_en) begin
         if (!cy_ff[39]) begin
            cx_ff <= cx_ff + dx;
            cy_ff <= cy_ff - dy;
            cz_ff <= cz_ff + atan_val;
         end else begin
            cx_ff <= cx_ff - dx;
            cy_ff <= cy_ff + dy;
            cz_ff <= cz_ff - atan_val;
         end
      end
   end

   // Result beat.
   assign rsp_tilt_first    = q0_ff;
   assign rsp_tilt_second   = q1_ff;
   assign rsp_rate_first    = sat16(60'(rate0_ff));
   assign rsp_rate_second   = sat16(60'(rate1_ff));
   assign rsp_rate_yaw      = gz_ff;
   assign rsp_accel_invalid = invalid_ff;

endmodule
